FILE: sv/lasu_pkg.sv
// ----------------------------------------------------------------------------
// lasu_pkg: shared types and constants of the local alignment scorer
// Sizes, field widths, register and function codes, and the link record
// that passes from one cell of the scoring chain to the next.
// ----------------------------------------------------------------------------
`default_nettype none

package lasu_pkg;

  // sizes
  localparam int MAX_REF_LEN   = 1024;
  localparam int MAX_QUERY_LEN = 65536;
  localparam int IDX_W   = $clog2(MAX_REF_LEN);
  localparam int LEN_W   = $clog2(MAX_REF_LEN + 1);
  localparam int INFL_W  = $clog2(MAX_REF_LEN + 2);

  // field widths
  localparam int SYM_W   = 8;
  localparam int SCORE_W = 14;
  localparam int ROW_W   = 17;
  localparam int COL_W   = 11;
  localparam int CFG_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int WIDE_W  = SCORE_W + 2;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [ROW_W-1:0]   QUERY_LIMIT = ROW_W'(MAX_QUERY_LEN);
  localparam logic [LEN_W-1:0]   REF_LIMIT = LEN_W'(MAX_REF_LEN);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] MATCH_RST    = 4'd3;
  localparam logic [CFG_W-1:0] MISMATCH_RST = 4'd3;
  localparam logic [CFG_W-1:0] GAP_RST      = 4'd2;

  // item kinds
  localparam logic FUNC_REF   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // scoring weights seen by every cell
  typedef struct packed {
    logic [CFG_W-1:0] match_bonus;
    logic [CFG_W-1:0] mismatch_penalty;
    logic [CFG_W-1:0] gap_penalty;
  } weights_t;

  // one query row travelling down the chain
  typedef struct packed {
    logic             valid;
    logic             skip;
    logic             last;
    logic             ovf;
    logic [SYM_W-1:0] sym;
  } token_t;

  // what one cell hands its right neighbor
  typedef struct packed {
    token_t             tok;
    logic [SCORE_W-1:0] s;
    logic [SCORE_W-1:0] d;
    logic [SCORE_W-1:0] best;
    logic [COL_W-1:0]   col;
  } link_t;

endpackage

`default_nettype wire

FILE: sv/lasu_in_if.sv
// ----------------------------------------------------------------------------
// lasu_in_if: input channel of the local alignment scorer
// Valid/ready channel carrying reference and query bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lasu_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, func, symbol, last, input ready);
  modport sink   (input valid, func, symbol, last, output ready);
endinterface

`default_nettype wire

FILE: sv/lasu_out_if.sv
// ----------------------------------------------------------------------------
// lasu_out_if: result channel of the local alignment scorer
// Valid/ready channel carrying one alignment result per query.
// ----------------------------------------------------------------------------
`default_nettype none

interface lasu_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] best_score;
  logic [16:0] end_row;
  logic [10:0] end_col;
  logic        overflow;

  modport source (output valid, best_score, end_row, end_col, overflow, input ready);
  modport sink   (input valid, best_score, end_row, end_col, overflow, output ready);
endinterface

`default_nettype wire

FILE: sv/lasu_cell.sv
// ----------------------------------------------------------------------------
// lasu_cell: one column of the scoring chain
// Holds one reference byte and its column score, scores each passing query
// row and hands score, diagonal and running row best to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lasu_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire logic                       clr,
  input  wire logic                       wr,
  input  wire logic [lasu_pkg::SYM_W-1:0] wr_sym,
  input  wire logic [lasu_pkg::COL_W-1:0] col,
  input  wire lasu_pkg::weights_t         wts,
  input  wire lasu_pkg::link_t            link_in,
  output      lasu_pkg::link_t            link_out
);
  import lasu_pkg::*;

  logic [SYM_W-1:0]   ref_r;
  logic               act_r, act_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;
  link_t              link_r, link_nxt;

  logic signed [WIDE_W-1:0] diag_w, up_w, left_w, best_w;
  logic [SCORE_W-1:0]       s_w;
  logic                     work;

  // cell score: max of diagonal, up, left and zero, saturated
  always_comb begin
    diag_w = signed'({2'b00, link_in.d});
    if (ref_r == link_in.tok.sym) begin
      diag_w = diag_w + signed'(WIDE_W'(wts.match_bonus));
    end else begin
      diag_w = diag_w - signed'(WIDE_W'(wts.mismatch_penalty));
    end
    up_w   = signed'({2'b00, score_r}) - signed'(WIDE_W'(wts.gap_penalty));
    left_w = signed'({2'b00, link_in.s}) - signed'(WIDE_W'(wts.gap_penalty));
    best_w = diag_w;
    if (up_w > best_w) best_w = up_w;
    if (left_w > best_w) best_w = left_w;
    if (best_w < 0) begin
      s_w = '0;
    end else if (best_w > signed'({2'b00, SCORE_MAX})) begin
      s_w = SCORE_MAX;
    end else begin
      s_w = best_w[SCORE_W-1:0];
    end
  end

  // next state of the column and of the outgoing link
  always_comb begin
    work      = link_in.tok.valid && !link_in.tok.skip && act_r;
    link_nxt  = link_in;
    score_nxt = score_r;
    act_nxt   = act_r;
    if (work) begin
      link_nxt.s = s_w;
      link_nxt.d = score_r;
      if (s_w > link_in.best) begin
        link_nxt.best = s_w;
        link_nxt.col  = col;
      end
      score_nxt = s_w;
    end
    if (link_in.tok.valid && link_in.tok.last) score_nxt = '0;
    if (clr) begin
      act_nxt   = 1'b0;
      score_nxt = '0;
    end
    if (wr) act_nxt = 1'b1;
  end

  // column state and outgoing link
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      score_r <= '0;
      link_r  <= '0;
    end else if (adv) begin
      act_r   <= act_nxt;
      score_r <= score_nxt;
      link_r  <= link_nxt;
    end
  end

  // reference byte
  always_ff @(posedge clk) begin
    if (adv && wr) ref_r <= wr_sym;
  end

  assign link_out = link_r;

endmodule

`default_nettype wire

FILE: sv/lasu_tail.sv
// ----------------------------------------------------------------------------
// lasu_tail: best tracking and result register
// Counts rows leaving the chain, keeps the first best cell in row-major
// order and loads the result register on the last row of a query.
// ----------------------------------------------------------------------------
`default_nettype none

module lasu_tail (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            clr,
  input  wire lasu_pkg::link_t link_in,
  output      logic            adv,
  lasu_out_if.source           out_ch
);
  import lasu_pkg::*;

  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [SCORE_W-1:0] best_r, best_nxt;
  logic [ROW_W-1:0]   brow_r, brow_nxt;
  logic [COL_W-1:0]   bcol_r, bcol_nxt;
  logic               ov_r, ov_nxt;
  logic               load;
  logic [SCORE_W-1:0] res_best_r;
  logic [ROW_W-1:0]   res_row_r;
  logic [COL_W-1:0]   res_col_r;
  logic               res_ovf_r;

  // chain moves unless a result waits and is not taken
  assign adv  = !(ov_r && !out_ch.ready);
  assign load = adv && link_in.tok.valid && link_in.tok.last;

  // running best over finished rows
  always_comb begin
    row_nxt  = row_r;
    best_nxt = best_r;
    brow_nxt = brow_r;
    bcol_nxt = bcol_r;
    if (link_in.tok.valid && !link_in.tok.skip) begin
      row_nxt = row_r + 1'b1;
      if (link_in.best > best_r) begin
        best_nxt = link_in.best;
        brow_nxt = row_nxt;
        bcol_nxt = link_in.col;
      end
    end
  end

  // result valid
  always_comb begin
    ov_nxt = ov_r && !out_ch.ready;
    if (load) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      best_r <= '0;
      brow_r <= '0;
      bcol_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (clr || load) begin
        row_r  <= '0;
        best_r <= '0;
        brow_r <= '0;
        bcol_r <= '0;
      end else if (adv) begin
        row_r  <= row_nxt;
        best_r <= best_nxt;
        brow_r <= brow_nxt;
        bcol_r <= bcol_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_best_r <= best_nxt;
      res_row_r  <= brow_nxt;
      res_col_r  <= bcol_nxt;
      res_ovf_r  <= link_in.tok.ovf;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.best_score = res_best_r;
  assign out_ch.end_row    = res_row_r;
  assign out_ch.end_col    = res_col_r;
  assign out_ch.overflow   = res_ovf_r;

endmodule

`default_nettype wire

FILE: sv/local_alignment_scorer_unit.sv
// ----------------------------------------------------------------------------
// local_alignment_scorer_unit: Smith-Waterman scorer with linear gaps
// Reference bytes load a chain of cells; each query byte then sweeps the
// chain as one row of the score matrix and the tail keeps the best cell.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       payload
//  in_ch    in   valid/ready     func, symbol, last
//  out_ch   out  valid/ready     best_score, end_row, end_col, overflow
//  cfg_*    in   cfg_we          cfg_idx, cfg_data
//
//  A query item enters the 1024-cell chain; a new one can follow every
//  cycle while the chain is not frozen, and its row passes through every cell.
//  A reference item waits until no row is left in the chain.
//  A pending result that is not taken freezes the whole chain.
//  Reset clears all column scores, the reference length and the best.
// ----------------------------------------------------------------------------
`default_nettype none

module local_alignment_scorer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [lasu_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [lasu_pkg::CFG_W-1:0]     cfg_data,
  lasu_in_if.sink                             in_ch,
  lasu_out_if.source                          out_ch
);
  import lasu_pkg::*;

  weights_t         wts_r;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             cmp_r, cmp_nxt;
  logic             cut_r, cut_nxt;
  logic [ROW_W-1:0] qcnt_r, qcnt_nxt;
  logic             qovf_r, qovf_nxt;
  logic [INFL_W-1:0] infl_r;

  logic             adv, busy, acc, acc_ref, acc_q, clr, wr;
  logic [LEN_W-1:0] wr_pos;
  link_t            links [MAX_REF_LEN+1];
  token_t           tok_in;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wts_r.match_bonus      <= MATCH_RST;
      wts_r.mismatch_penalty <= MISMATCH_RST;
      wts_r.gap_penalty      <= GAP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MATCH:    wts_r.match_bonus      <= cfg_data;
        REG_MISMATCH: wts_r.mismatch_penalty <= cfg_data;
        REG_GAP:      wts_r.gap_penalty      <= cfg_data;
        default:      ;
      endcase
    end
  end

  // input handshake: reference items wait for an empty chain
  assign busy        = (infl_r != '0);
  assign in_ch.ready = adv && !(in_ch.func == FUNC_REF && busy);
  assign acc         = in_ch.valid && in_ch.ready;
  assign acc_ref     = acc && in_ch.func == FUNC_REF;
  assign acc_q       = acc && in_ch.func == FUNC_QUERY;
  assign clr         = acc_ref && cmp_r;
  assign wr_pos      = clr ? '0 : len_r;
  assign wr          = acc_ref && (wr_pos < REF_LIMIT);

  // head bookkeeping for reference and query items
  always_comb begin
    len_nxt  = len_r;
    cmp_nxt  = cmp_r;
    cut_nxt  = cut_r;
    qcnt_nxt = qcnt_r;
    qovf_nxt = qovf_r;
    tok_in   = '0;
    if (acc_ref) begin
      if (clr) begin
        cut_nxt  = 1'b0;
        qcnt_nxt = '0;
        qovf_nxt = 1'b0;
      end
      cmp_nxt = in_ch.last;
      if (wr) begin
        len_nxt = wr_pos + 1'b1;
      end else begin
        len_nxt = wr_pos;
        cut_nxt = 1'b1;
      end
    end else if (acc_q) begin
      cmp_nxt      = 1'b1;
      tok_in.valid = 1'b1;
      tok_in.last  = in_ch.last;
      tok_in.sym   = in_ch.symbol;
      if (qcnt_r < QUERY_LIMIT) begin
        qcnt_nxt = qcnt_r + 1'b1;
      end else begin
        tok_in.skip = 1'b1;
        qovf_nxt    = 1'b1;
      end
      tok_in.ovf = cut_r || qovf_nxt;
      if (in_ch.last) begin
        qcnt_nxt = '0;
        qovf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      cmp_r  <= 1'b0;
      cut_r  <= 1'b0;
      qcnt_r <= '0;
      qovf_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      cmp_r  <= cmp_nxt;
      cut_r  <= cut_nxt;
      qcnt_r <= qcnt_nxt;
      qovf_r <= qovf_nxt;
    end
  end

  // rows in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      infl_r <= '0;
    end else begin
      infl_r <= infl_r + INFL_W'(acc_q) - INFL_W'(adv && links[MAX_REF_LEN].tok.valid);
    end
  end

  // chain of cells
  always_comb begin
    links[0]     = '0;
    links[0].tok = tok_in;
  end

  for (genvar j = 0; j < MAX_REF_LEN; j++) begin : g_cell
    lasu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .clr      (clr),
      .wr       (wr && wr_pos[IDX_W-1:0] == IDX_W'(j)),
      .wr_sym   (in_ch.symbol),
      .col      (COL_W'(j + 1)),
      .wts      (wts_r),
      .link_in  (links[j]),
      .link_out (links[j+1])
    );
  end

  lasu_tail u_tail (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (clr),
    .link_in (links[MAX_REF_LEN]),
    .adv     (adv),
    .out_ch  (out_ch)
  );

  // checks
  a_ref_empty: assert property (@(posedge clk) disable iff (!rst_n)
    acc_ref |-> infl_r == '0)
    else $error("reference item taken with rows in flight");

  a_infl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    infl_r <= INFL_W'(MAX_REF_LEN))
    else $error("more rows in flight than cells");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= REF_LIMIT)
    else $error("reference length past the chain");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> infl_r == $past(infl_r))
    else $error("rows moved while the chain was frozen");

endmodule

`default_nettype wire

FILE: dv/tb_local_alignment_scorer_unit.sv
// ----------------------------------------------------------------------------
// tb_local_alignment_scorer_unit: regression bench of the alignment scorer
// Drives reference and query items with random gaps and result stalls,
// predicts each alignment score, end position and overflow flag, and
// compares every result item in order against the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_local_alignment_scorer_unit;
  import lasu_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 1100;
  localparam int HOLD_CYCLES    = 3000;

  // index that maps to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               ovf;
  } align_result_t;

  // alignment predictor and store of expected results
  class align_scoreboard;
    int unsigned   match_w, mismatch_w, gap_w;
    logic [7:0]    ref_bytes[MAX_REF_LEN];
    int            col_score[MAX_REF_LEN];
    int unsigned   ref_len, row_count, best, best_r, best_c;
    bit            ref_done, ovf_seen, ref_cut;
    align_result_t expected_q[$];
    int            errors;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_MATCH) match_w = 32'(val);
      else if (idx == REG_MISMATCH) mismatch_w = 32'(val);
      else if (idx == REG_GAP) gap_w = 32'(val);
    endfunction

    function void clear_query();
      foreach (col_score[j]) col_score[j] = 0;
      row_count = 0;
      best = 0;
      best_r = 0;
      best_c = 0;
      ovf_seen = ref_cut;
    endfunction

    function void init();
      match_w = 32'(MATCH_RST);
      mismatch_w = 32'(MISMATCH_RST);
      gap_w = 32'(GAP_RST);
      ref_len = 0;
      ref_done = 0;
      ref_cut = 0;
      errors = 0;
      clear_query();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic f, logic [7:0] s, logic l);
      int diag, left, up, sc;
      align_result_t r;
      diag = 0;
      left = 0;
      if (f == FUNC_REF) begin
        if (ref_done) begin
          ref_len = 0;
          ref_done = 0;
          ref_cut = 0;
          clear_query();
        end
        if (ref_len < MAX_REF_LEN) begin
          ref_bytes[ref_len] = s;
          ref_len++;
        end else begin
          ref_cut = 1;
          ovf_seen = 1;
        end
        if (l) ref_done = 1;
        return;
      end
      ref_done = 1;
      if (row_count < MAX_QUERY_LEN) begin
        row_count++;
        // one row of the score matrix
        for (int j = 0; j < ref_len; j++) begin
          up = col_score[j];
          sc = diag + ((ref_bytes[j] == s) ? int'(match_w) : -int'(mismatch_w));
          if (up - int'(gap_w) > sc) sc = up - int'(gap_w);
          if (left - int'(gap_w) > sc) sc = left - int'(gap_w);
          if (sc < 0) sc = 0;
          if (sc > int'(SCORE_MAX)) sc = int'(SCORE_MAX);
          if (sc > int'(best)) begin
            best = sc;
            best_r = row_count;
            best_c = j + 1;
          end
          diag = up;
          col_score[j] = sc;
          left = sc;
        end
      end else begin
        ovf_seen = 1;
      end
      if (!l) return;
      r.score = best[SCORE_W-1:0];
      r.row = best_r[ROW_W-1:0];
      r.col = best_c[COL_W-1:0];
      r.ovf = ovf_seen;
      expected_q = {expected_q, r};
      clear_query();
    endfunction

    function void check_result(align_result_t got);
      align_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item %p", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.score !== e.score) begin
        $display("%0t: best_score expected %0d actual %0d", $time, e.score, got.score);
        errors++;
      end
      if (got.row !== e.row) begin
        $display("%0t: end_row expected %0d actual %0d", $time, e.row, got.row);
        errors++;
      end
      if (got.col !== e.col) begin
        $display("%0t: end_col expected %0d actual %0d", $time, e.col, got.col);
        errors++;
      end
      if (got.ovf !== e.ovf) begin
        $display("%0t: overflow expected %0d actual %0d", $time, e.ovf, got.ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  lasu_in_if  in_ch ();
  lasu_out_if out_ch ();

  local_alignment_scorer_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  align_scoreboard sb = new();
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned n_items = 0;
  bit hold_start = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;

  always #6 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.func = 0;
    in_ch.symbol = 0;
    in_ch.last = 0;
    out_ch.ready = 0;
  end

  // result receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_start) begin
      hold_cnt = HOLD_CYCLES;
      hold_start = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // result check
  always @(posedge clk) begin
    align_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.score = out_ch.best_score;
      got.row = out_ch.end_row;
      got.col = out_ch.end_col;
      got.ovf = out_ch.overflow;
      sb.check_result(got);
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("local_alignment_scorer_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic f, logic [7:0] s, logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.symbol <= s;
    in_ch.last <= l;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(f, s, l);
    n_items++;
  endtask

  // wait for every result, then let the chain empty
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic write_weights(int m, int mm, int g);
    write_reg(REG_MATCH, CFG_W'(m));
    write_reg(REG_MISMATCH, CFG_W'(mm));
    write_reg(REG_GAP, CFG_W'(g));
  endtask

  function automatic logic [7:0] pick_sym();
    if ($urandom_range(7) == 0) return 8'($urandom_range(255));
    return 8'(8'h41 + $urandom_range(3));
  endfunction

  // one reference followed by a few queries, sometimes broken
  task automatic send_job();
    int rl, nq, ql;
    rl = $urandom_range(12, 1);
    nq = $urandom_range(4, 1);
    for (int i = 0; i < rl; i++) begin
      // noise: leave the reference open so a query closes it
      if (i == rl - 1 && $urandom_range(9) == 0) send_item(FUNC_REF, pick_sym(), 1'b0);
      else send_item(FUNC_REF, pick_sym(), i == rl - 1);
    end
    for (int q = 0; q < nq; q++) begin
      ql = $urandom_range(8, 1);
      for (int i = 0; i < ql; i++) begin
        // noise: abandon the query with a new reference
        if ($urandom_range(49) == 0) return;
        send_item(FUNC_QUERY, pick_sym(), i == ql - 1);
      end
    end
  endtask

  task automatic random_phase(int unsigned target);
    int unsigned stop_at;
    stop_at = n_items + target;
    while (n_items < stop_at) send_job();
    drain();
  endtask

  initial begin
    sb.init();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty reference, extremes of symbols and weights
    write_weights(MATCH_RST, MISMATCH_RST, GAP_RST);
    write_reg(REG_UNUSED, 4'hf);
    send_item(FUNC_QUERY, 8'h00, 1'b1);
    send_item(FUNC_REF, 8'h00, 1'b0);
    send_item(FUNC_REF, 8'hff, 1'b1);
    send_item(FUNC_QUERY, 8'hff, 1'b1);
    send_item(FUNC_QUERY, 8'h00, 1'b0);
    send_item(FUNC_QUERY, 8'hff, 1'b1);
    // reference after a complete one abandons the query in progress
    send_item(FUNC_QUERY, 8'h00, 1'b0);
    send_item(FUNC_REF, 8'h55, 1'b0);
    send_item(FUNC_REF, 8'haa, 1'b0);
    // query before the reference is complete closes it
    send_item(FUNC_QUERY, 8'haa, 1'b0);
    send_item(FUNC_QUERY, 8'h55, 1'b1);
    drain();
    write_weights(15, 0, 0);
    send_item(FUNC_REF, 8'h01, 1'b0);
    send_item(FUNC_REF, 8'h02, 1'b1);
    send_item(FUNC_QUERY, 8'h02, 1'b0);
    send_item(FUNC_QUERY, 8'h01, 1'b1);
    drain();
    write_weights(0, 15, 15);
    send_item(FUNC_QUERY, 8'h01, 1'b1);
    drain();
    write_weights(15, 15, 15);
    send_item(FUNC_QUERY, 8'h02, 1'b1);
    drain();

    // reference too long: bytes past the store are dropped and flagged
    write_weights(MATCH_RST, MISMATCH_RST, GAP_RST);
    for (int i = 0; i < MAX_REF_LEN + 6; i++)
      send_item(FUNC_REF, pick_sym(), i == MAX_REF_LEN + 5);
    send_item(FUNC_QUERY, 8'h41, 1'b0);
    send_item(FUNC_QUERY, 8'h42, 1'b1);

    // receiver holds off while queries keep coming and the input stalls
    send_item(FUNC_REF, 8'h41, 1'b0);
    send_item(FUNC_REF, 8'h42, 1'b1);
    hold_start = 1;
    for (int i = 0; i < 30; i++) send_item(FUNC_QUERY, pick_sym(), i % 3 == 2);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    for (int i = 0; i < 30; i++) send_item(FUNC_QUERY, pick_sym(), i % 3 == 2);
    drain();

    // random phases under different weights and idling
    write_weights($urandom_range(15), $urandom_range(15), $urandom_range(15));
    src_idle_pct = 0;   snk_stall_pct = 0;
    random_phase(85);
    write_weights(15, 15, 0);
    src_idle_pct = 86;  snk_stall_pct = 0;
    random_phase(85);
    write_weights($urandom_range(15), $urandom_range(15), $urandom_range(15));
    src_idle_pct = 0;   snk_stall_pct = 86;
    random_phase(85);
    write_weights(0, 0, 15);
    src_idle_pct = 32;  snk_stall_pct = 32;
    random_phase(85);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("local_alignment_scorer_unit regression: pass");
    end else begin
      $display("local_alignment_scorer_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/lasu_pkg.sv
sv/lasu_in_if.sv
sv/lasu_out_if.sv
sv/lasu_cell.sv
sv/lasu_tail.sv
sv/local_alignment_scorer_unit.sv
dv/tb_local_alignment_scorer_unit.sv
